// File: rtl/core/atrp_pkg.sv
// shared types, codes and constants of the prompt and terminator matcher
package atrp_pkg;

	// default limits handed to the top level parameters
	localparam int DEF_MAX_PROMPT     = 24;
	localparam int DEF_MAX_TERMINATOR = 16;
	localparam int DEF_MAX_RESPONSE   = 32;

	// field widths fixed by the register map and word format
	localparam int CHAR_W      = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int POS_W       = 5;
	localparam int SPACE_W     = 6;
	localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;

	// carriage return ends gathering
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PROMPT_LOW,
		CFG_PROMPT_MID,
		CFG_PROMPT_HIGH,
		CFG_PROMPT_LENGTH,
		CFG_TERM_LOW,
		CFG_TERM_HIGH,
		CFG_TERM_LENGTH,
		CFG_CAPACITY
	} cfg_index_t;

	// reset value of the terminator length register
	localparam logic [POS_W-1:0] TERM_LENGTH_RST = 5'd4;

	// matcher phase
	typedef enum logic [1:0] {
		PH_PROMPT,
		PH_GATHER,
		PH_TERM
	} phase_t;

	// input word action codes
	localparam logic ACT_START = 1'b0;

	// classified command between front and back
	typedef enum logic {
		CMD_START,
		CMD_CHAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              is_cr;
		logic [CHAR_W-1:0] ch;
	} cmd_t;

	// input word
	typedef struct packed {
		logic              action;
		logic [CHAR_W-1:0] rx_char;
	} in_word_t;

	// result word
	typedef struct packed {
		logic              store_valid;
		logic [CHAR_W-1:0] store_char;
		logic [POS_W-1:0]  store_index;
		logic              gathering;
		logic              matched;
	} out_word_t;

endpackage

// File: rtl/core/atrp_front.sv
// front stage: accepts input words and classifies them into commands
module atrp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  atrp_pkg::in_word_t in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output atrp_pkg::cmd_t    cmd_data
);
	import atrp_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;

	// stage is free when empty or draining into the queue this cycle
	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd_data  = cmd_s1;

	// classify the word
	always_comb begin
		cmd_d.kind  = (in_data.action == ACT_START) ? CMD_START : CMD_CHAR;
		cmd_d.is_cr = (in_data.rx_char == CHAR_CR);
		cmd_d.ch    = in_data.rx_char;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: rtl/core/atrp_queue.sv
// two-entry command queue between front and back
module atrp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  atrp_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output atrp_pkg::cmd_t pop_data
);
	import atrp_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/atrp_back.sv
// back end: configuration registers, prompt and terminator matching, result register
module atrp_back #(
	parameter int MAX_PROMPT     = atrp_pkg::DEF_MAX_PROMPT,
	parameter int MAX_TERMINATOR = atrp_pkg::DEF_MAX_TERMINATOR,
	parameter int MAX_RESPONSE   = atrp_pkg::DEF_MAX_RESPONSE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [atrp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [atrp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  atrp_pkg::cmd_t                       cmd_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output atrp_pkg::out_word_t                  out_data
);
	import atrp_pkg::*;

	// configuration
	logic [CHAR_W-1:0]  prompt_q [MAX_PROMPT];
	logic [CHAR_W-1:0]  term_q [MAX_TERMINATOR];
	logic [POS_W-1:0]   prompt_len_q;
	logic [POS_W-1:0]   term_len_q;
	logic [SPACE_W-1:0] capacity_q;

	// matcher state
	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   ppos_q, ppos_d;
	logic [POS_W-1:0]   tpos_q, tpos_d;
	logic [SPACE_W-1:0] space_q, space_d;
	logic [POS_W-1:0]   wpos_q, wpos_d;
	logic               done_q, done_d;

	// result register
	logic      out_valid_q;
	out_word_t out_q, out_d;

	logic               take;
	logic               is_start;
	logic [POS_W-1:0]   plen;
	logic [POS_W-1:0]   tlen;
	logic [SPACE_W-1:0] eff_cap;
	logic [CHAR_W-1:0]  pchar;
	logic [CHAR_W-1:0]  tchar;
	logic [POS_W-1:0]   ppos_inc;
	logic [POS_W-1:0]   tpos_inc;
	logic               prompt_step;
	logic               gather_step;
	logic               gather_store;
	logic               prompt_hit;
	logic               term_hit;

	assign take      = !out_valid_q || out_ready;
	assign cmd_ready = take;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign is_start  = (cmd_data.kind == CMD_START);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PROMPT; k++) begin
				prompt_q[k] <= '0;
			end
			for (int k = 0; k < MAX_TERMINATOR; k++) begin
				term_q[k] <= '0;
			end
			prompt_len_q <= '0;
			term_len_q   <= TERM_LENGTH_RST;
			capacity_q   <= '0;
		end else if (cfg_we) begin
			for (int k = 0; k < MAX_PROMPT; k++) begin
				if (cfg_index == (((k >> 3) == 0) ? CFG_PROMPT_LOW :
						((k >> 3) == 1) ? CFG_PROMPT_MID : CFG_PROMPT_HIGH)) begin
					prompt_q[k] <= cfg_data[(k & 7) * CHAR_W +: CHAR_W];
				end
			end
			for (int k = 0; k < MAX_TERMINATOR; k++) begin
				if (cfg_index == (((k >> 3) == 0) ? CFG_TERM_LOW : CFG_TERM_HIGH)) begin
					term_q[k] <= cfg_data[(k & 7) * CHAR_W +: CHAR_W];
				end
			end
			if (cfg_index == CFG_PROMPT_LENGTH) begin
				prompt_len_q <= cfg_data[POS_W-1:0];
			end
			if (cfg_index == CFG_TERM_LENGTH) begin
				term_len_q <= cfg_data[POS_W-1:0];
			end
			if (cfg_index == CFG_CAPACITY) begin
				capacity_q <= cfg_data[SPACE_W-1:0];
			end
		end
	end

	// clamped lengths and capacity
	always_comb begin
		plen = (int'(prompt_len_q) > MAX_PROMPT) ? POS_W'(MAX_PROMPT) : prompt_len_q;
		if (term_len_q == '0) begin
			tlen = POS_W'(1);
		end else if (int'(term_len_q) > MAX_TERMINATOR) begin
			tlen = POS_W'(MAX_TERMINATOR);
		end else begin
			tlen = term_len_q;
		end
		eff_cap = (int'(capacity_q) > MAX_RESPONSE) ? SPACE_W'(MAX_RESPONSE) : capacity_q;
	end

	// character select at the current match positions
	always_comb begin
		pchar = '0;
		for (int k = 0; k < MAX_PROMPT; k++) begin
			if (int'(ppos_q) == k) begin
				pchar = prompt_q[k];
			end
		end
		tchar = '0;
		for (int k = 0; k < MAX_TERMINATOR; k++) begin
			if (int'(tpos_q) == k) begin
				tchar = term_q[k];
			end
		end
	end

	// per-character decisions
	always_comb begin
		ppos_inc     = ppos_q + POS_W'(1);
		tpos_inc     = tpos_q + POS_W'(1);
		prompt_step  = !done_q && (plen != '0) && (phase_q == PH_PROMPT);
		gather_step  = !done_q && (plen != '0) && (phase_q == PH_GATHER)
			&& (capacity_q != '0);
		gather_store = gather_step && !cmd_data.is_cr && (space_q >= SPACE_W'(2));
		prompt_hit   = (ppos_q >= plen) || (cmd_data.ch == pchar);
		term_hit     = (tpos_q >= tlen) || (cmd_data.ch == tchar);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		ppos_d  = ppos_q;
		tpos_d  = tpos_q;
		space_d = space_q;
		wpos_d  = wpos_q;
		done_d  = done_q;
		if (is_start) begin
			phase_d = PH_PROMPT;
			ppos_d  = '0;
			tpos_d  = '0;
			space_d = eff_cap;
			wpos_d  = '0;
			done_d  = 1'b0;
		end else if (!done_q) begin
			// prompt and gathering come before the terminator for the same byte
			if (prompt_step) begin
				if (prompt_hit) begin
					ppos_d = ppos_inc;
					if (ppos_inc >= plen) begin
						phase_d = PH_GATHER;
					end
				end else begin
					ppos_d = (cmd_data.ch == prompt_q[0]) ? POS_W'(1) : '0;
				end
			end else if (gather_step) begin
				if (gather_store) begin
					wpos_d  = wpos_q + POS_W'(1);
					space_d = space_q - SPACE_W'(1);
				end else begin
					phase_d = PH_TERM;
				end
			end
			if (term_hit) begin
				tpos_d = tpos_inc;
				if (tpos_inc >= tlen) begin
					done_d = 1'b1;
				end
			end else begin
				tpos_d = (cmd_data.ch == term_q[0]) ? POS_W'(1) : '0;
			end
		end
	end

	// result word
	always_comb begin
		out_d = '0;
		if (!is_start) begin
			out_d.store_valid = gather_store;
			out_d.store_char  = gather_store ? cmd_data.ch : '0;
			out_d.store_index = gather_store ? wpos_q : '0;
			out_d.gathering   = (phase_d == PH_GATHER) && (plen != '0);
			out_d.matched     = done_d;
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PROMPT;
			ppos_q      <= '0;
			tpos_q      <= '0;
			space_q     <= '0;
			wpos_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				phase_q <= phase_d;
				ppos_q  <= ppos_d;
				tpos_q  <= tpos_d;
				space_q <= space_d;
				wpos_q  <= wpos_d;
				done_q  <= done_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take && cmd_valid) begin
			out_q <= out_d;
		end
	end

	// done is sticky until a start word
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !(take && cmd_valid && is_start) |=> done_q)
		else $error("done flag dropped without a start word");

	// a stored byte only comes out while gathering or together with the match
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.store_valid |-> out_q.gathering && !out_q.matched || out_q.matched)
		else $error("byte stored outside gathering");

	// a start word leaves cleared match state
	assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_valid && is_start |=>
			ppos_q == '0 && tpos_q == '0 && wpos_q == '0 && !done_q)
		else $error("start word did not clear match state");

endmodule

// File: rtl/core/at_response_prompt_terminator_matcher.sv
// top level of the reply prompt and terminator matcher: front, queue and back
// Takes one modem reply byte per word and returns one result word for every input word,
// sustaining one word per clock while out_ready stays high; a word passes in turn through the
// front register, the two-entry queue and the back result register, and the only serial
// path is the update of the match positions in the back end. Action 0 starts a new wait
// and clears all match state; action 1 delivers a byte. Configuration writes should be
// made only while no words are in flight.
module at_response_prompt_terminator_matcher #(
	parameter int MAX_PROMPT     = atrp_pkg::DEF_MAX_PROMPT,
	parameter int MAX_TERMINATOR = atrp_pkg::DEF_MAX_TERMINATOR,
	parameter int MAX_RESPONSE   = atrp_pkg::DEF_MAX_RESPONSE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [atrp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [atrp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  atrp_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output atrp_pkg::out_word_t              out_data
);
	import atrp_pkg::*;

	logic f_valid;
	logic f_ready;
	cmd_t f_data;
	logic q_valid;
	logic q_ready;
	cmd_t q_data;

	// accept and classify
	atrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_data  (f_data)
	);

	// decoupling queue
	atrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	// matching and result
	atrp_back #(
		.MAX_PROMPT     (MAX_PROMPT),
		.MAX_TERMINATOR (MAX_TERMINATOR),
		.MAX_RESPONSE   (MAX_RESPONSE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd_data  (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
